@@ rtl/etfi_pkg.sv @@
// Shared types, constants and saturating arithmetic for the escape-time iterator.
// Used by every module of the block; depends on nothing.
package etfi_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 12;
    localparam int OUT_WIDTH   = ((COUNT_WIDTH + 7) / 8) * 8;
    localparam int CFG_WIDTH   = 12;

    localparam logic [1:0] CFG_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_VARIANT = 2'd1;
    localparam logic [1:0] CFG_MULT    = 2'd2;

    localparam logic [1:0] VAR_QUAD    = 2'd0;
    localparam logic [1:0] VAR_HEART   = 2'd1;
    localparam logic [1:0] VAR_CELTIC  = 2'd2;
    localparam logic [1:0] VAR_QUINTIC = 2'd3;

    localparam logic [2:0] TAG_R2 = 3'd0;
    localparam logic [2:0] TAG_I2 = 3'd1;
    localparam logic [2:0] TAG_X  = 3'd2;
    localparam logic [2:0] TAG_R4 = 3'd3;
    localparam logic [2:0] TAG_I4 = 3'd4;
    localparam logic [2:0] TAG_RI = 3'd5;
    localparam logic [2:0] TAG_NR = 3'd6;
    localparam logic [2:0] TAG_NI = 3'd7;

    localparam logic [127:0] ESC_LIMIT = 128'(1) << (2 * FRAC_BITS + 2);
    localparam logic [127:0] FRAC_MASK = (128'(1) << FRAC_BITS) - 128'(1);

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic        valid;
        logic [2:0]  tag;
        logic        neg;
        logic [63:0] ma;
        logic [63:0] mb;
    } t_iss;

    typedef struct packed {
        logic         valid;
        logic [2:0]   tag;
        logic         neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] acc;
    } t_pp;

    typedef struct packed {
        logic                valid;
        logic [2:0]          tag;
        logic signed [63:0]  res;
        logic [127:0]        prod;
    } t_mres;

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return $signed(s[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return $signed(s[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_abs(logic signed [63:0] a);
        if (a == S64_MIN) return S64_MAX;
        return a[63] ? -a : a;
    endfunction

    // shift-and-add over the five bits of the small signed factor
    function automatic logic signed [63:0] sat_scale(logic signed [63:0] a,
                                                     logic signed [4:0] k);
        logic signed [68:0] x;
        logic signed [68:0] p;
        x = {{5{a[63]}}, a};
        p = '0;
        for (int b = 0; b < 4; b++) begin
            if (k[b]) p = p + (x <<< b);
        end
        if (k[4]) p = p - (x <<< 4);
        if (p > $signed({{5{1'b0}}, S64_MAX})) return S64_MAX;
        if (p < $signed({{5{1'b1}}, S64_MIN})) return S64_MIN;
        return p[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] a);
        if (a > 64'sd2147483647) return 32'sh7fffffff;
        if (a < -64'sd2147483648) return 32'sh80000000;
        return a[31:0];
    endfunction

    function automatic t_iss mk_iss(logic signed [63:0] a, logic signed [63:0] b,
                                    logic [2:0] tag);
        t_iss r;
        r.valid = 1'b1;
        r.tag   = tag;
        r.neg   = a[63] ^ b[63];
        r.ma    = a[63] ? 64'(-a) : 64'(a);
        r.mb    = b[63] ? 64'(-b) : 64'(b);
        return r;
    endfunction

endpackage

@@ rtl/etfi_pp_cell.sv @@
// One partial-product cell of the multiplier chain: a 32x32 product added into
// the running sum, handed on to the next cell. Depends on etfi_pkg.
module etfi_pp_cell import etfi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_sel,
    input  t_pp        i_pp,
    output t_pp        o_pp
);
    logic [31:0]  w_ha, w_hb;
    logic [63:0]  w_prod;
    logic [127:0] w_shift;
    t_pp          n_pp, r_pp;

    always_comb begin
        w_ha    = i_sel[1] ? i_pp.ma[63:32] : i_pp.ma[31:0];
        w_hb    = i_sel[0] ? i_pp.mb[63:32] : i_pp.mb[31:0];
        w_prod  = w_ha * w_hb;
        w_shift = {64'd0, w_prod} << (7'(i_sel[1]) * 7'd32 + 7'(i_sel[0]) * 7'd32);
        n_pp     = i_pp;
        n_pp.acc = i_pp.acc + w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp.valid <= 1'b0;
        end else begin
            r_pp <= n_pp;
        end
    end

    assign o_pp = r_pp;
endmodule

@@ rtl/etfi_round_cell.sv @@
// Final cell of the multiplier chain: shift out the fraction, round toward
// minus infinity and saturate to 64 bits. Depends on etfi_pkg.
module etfi_round_cell import etfi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_pp   i_pp,
    output t_mres o_res
);
    logic [127:0] w_q, w_qr;
    logic         w_rem;
    t_mres        n_res, r_res;

    always_comb begin
        w_q   = i_pp.acc >> FRAC_BITS;
        w_rem = |(i_pp.acc & FRAC_MASK);
        w_qr  = w_q + 128'(i_pp.neg && w_rem);
        n_res.valid = i_pp.valid;
        n_res.tag   = i_pp.tag;
        n_res.prod  = i_pp.acc;
        if (!i_pp.neg) begin
            n_res.res = (|w_qr[127:63]) ? S64_MAX : $signed(w_qr[63:0]);
        end else begin
            n_res.res = (|w_qr[127:63]) ? S64_MIN : -$signed(w_qr[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

@@ rtl/etfi_mul.sv @@
// Fixed-point multiplier: a chain of four partial-product cells and a rounding
// cell. Depends on etfi_pkg, etfi_pp_cell and etfi_round_cell.
module etfi_mul import etfi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_iss  i_iss,
    output t_mres o_res
);
    t_pp w_stage [0:4];

    assign w_stage[0] = {i_iss, 128'd0};

    for (genvar k = 0; k < 4; k++) begin : g_cell
        etfi_pp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sel   (2'(k)),
            .i_pp    (w_stage[k]),
            .o_pp    (w_stage[k+1])
        );
    end

    etfi_round_cell u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pp    (w_stage[4]),
        .o_res   (o_res)
    );
endmodule

@@ rtl/escape_time_fractal_iterator_core.sv @@
// Escape-time fractal iterator: one pixel's z and c in, one iteration count out.
// Each iteration issues its products into a five-cell multiplier chain (four
// partial-product cells and a rounding cell; a product is back once it has
// passed the issue register and every cell of the chain). The quintic map
// issues further rounds of products per iteration; the quadratic, heart and
// celtic maps do not. A pixel runs until the limit stops it or it escapes,
// then its count is offered and held until taken. One pixel is in work at a
// time: the next word is taken once the count has left the output. Depends on
// etfi_pkg and etfi_mul.
module escape_time_fractal_iterator_core import etfi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_addr,
    input  logic [CFG_WIDTH-1:0]   i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_real, start_imag, const_real, const_imag
    input  logic [127:0]           s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // iter_count, zero padded
    output logic [OUT_WIDTH-1:0]   m_axis_tdata
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_ISS2  = 5'd2;
    localparam logic [4:0] S_ISS3  = 5'd3;
    localparam logic [4:0] S_WAIT1 = 5'd4;
    localparam logic [4:0] S_WAIT2 = 5'd5;
    localparam logic [4:0] S_NA    = 5'd6;
    localparam logic [4:0] S_NB    = 5'd7;
    localparam logic [4:0] S_Q1    = 5'd8;
    localparam logic [4:0] S_Q2    = 5'd9;
    localparam logic [4:0] S_Q3    = 5'd10;
    localparam logic [4:0] S_QW1   = 5'd11;
    localparam logic [4:0] S_QA    = 5'd12;
    localparam logic [4:0] S_QB    = 5'd13;
    localparam logic [4:0] S_QC    = 5'd14;
    localparam logic [4:0] S_QD    = 5'd15;
    localparam logic [4:0] S_QW2   = 5'd16;
    localparam logic [4:0] S_QE    = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0]               r_state, n_state;
    logic [COUNT_WIDTH-1:0]   r_lim;
    logic [1:0]               r_var;
    logic [2:0]               r_mul;
    logic signed [31:0]       r_zr, r_zi, r_cr, r_ci;
    logic [COUNT_WIDTH-1:0]   r_iter;
    logic [COUNT_WIDTH-1:0]   r_count;
    logic                     r_out_valid;
    logic signed [63:0]       r_res [0:7];
    logic [127:0]             r_p1raw;
    logic signed [63:0]       r_d, r_sx, r_t10, r_t5r, r_t5i, r_br, r_bi;
    t_iss                     r_iss, n_iss;
    t_mres                    w_res;
    logic signed [63:0]       w_zr, w_zi, w_xr, w_d;
    logic                     w_esc, w_i2_in;

    etfi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (r_iss),
        .o_res   (w_res)
    );

    assign w_zr    = 64'(r_zr);
    assign w_zi    = 64'(r_zi);
    assign w_xr    = (r_var == VAR_HEART) ? sat_abs(w_zr) : w_zr;
    assign w_d     = (r_var == VAR_CELTIC) ? sat_abs(r_d) : r_d;
    assign w_i2_in = w_res.valid && (w_res.tag == TAG_I2);
    assign w_esc   = (r_p1raw + w_res.prod) > ESC_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= COUNT_WIDTH'(256);
            r_var <= VAR_QUAD;
            r_mul <= 3'd2;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_LIMIT:   r_lim <= i_cfg_wdata[COUNT_WIDTH-1:0];
                CFG_VARIANT: r_var <= i_cfg_wdata[1:0];
                CFG_MULT:    r_mul <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_res[w_res.tag] <= w_res.res;
            if (w_res.tag == TAG_R2) r_p1raw <= w_res.prod;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_iss     = '0;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_CHECK;
            S_CHECK: begin
                if (r_iter >= r_lim) begin
                    n_state = S_OUT;
                end else begin
                    n_iss   = mk_iss(w_zr, w_zr, TAG_R2);
                    n_state = S_ISS2;
                end
            end
            S_ISS2: begin
                n_iss   = mk_iss(w_zi, w_zi, TAG_I2);
                n_state = S_ISS3;
            end
            S_ISS3: begin
                if (r_var != VAR_QUINTIC) n_iss = mk_iss(w_xr, w_zi, TAG_X);
                n_state = S_WAIT1;
            end
            S_WAIT1: begin
                if (w_i2_in) begin
                    if (w_esc) n_state = S_OUT;
                    else if (r_var == VAR_QUINTIC) n_state = S_Q1;
                    else n_state = S_WAIT2;
                end
            end
            S_WAIT2: if (w_res.valid && w_res.tag == TAG_X) n_state = S_NA;
            S_NA:    n_state = S_NB;
            S_NB:    n_state = S_CHECK;
            S_Q1: begin
                n_iss   = mk_iss(r_res[TAG_R2], r_res[TAG_R2], TAG_R4);
                n_state = S_Q2;
            end
            S_Q2: begin
                n_iss   = mk_iss(r_res[TAG_I2], r_res[TAG_I2], TAG_I4);
                n_state = S_Q3;
            end
            S_Q3: begin
                n_iss   = mk_iss(r_res[TAG_R2], r_res[TAG_I2], TAG_RI);
                n_state = S_QW1;
            end
            S_QW1:   if (w_res.valid && w_res.tag == TAG_RI) n_state = S_QA;
            S_QA:    n_state = S_QB;
            S_QB:    n_state = S_QC;
            S_QC: begin
                n_iss   = mk_iss(w_zr, r_br, TAG_NR);
                n_state = S_QD;
            end
            S_QD: begin
                n_iss   = mk_iss(w_zi, r_bi, TAG_NI);
                n_state = S_QW2;
            end
            S_QW2:   if (w_res.valid && w_res.tag == TAG_NI) n_state = S_QE;
            S_QE:    n_state = S_CHECK;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss.valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            r_iss   <= n_iss;
            if (r_state == S_IDLE && s_axis_tvalid) r_iter <= '0;
            if (r_state == S_NB || r_state == S_QE) r_iter <= r_iter + 1'b1;
            if (r_state != S_OUT && n_state == S_OUT) begin
                r_out_valid <= 1'b1;
                r_count     <= r_iter;
            end
            if (r_state == S_OUT && m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_zr <= $signed(s_axis_tdata[31:0]);
                r_zi <= $signed(s_axis_tdata[63:32]);
                r_cr <= $signed(s_axis_tdata[95:64]);
                r_ci <= $signed(s_axis_tdata[127:96]);
            end
            S_NA: begin
                r_d  <= sat_sub(r_res[TAG_R2], r_res[TAG_I2]);
                r_sx <= sat_scale(r_res[TAG_X], {{2{r_mul[2]}}, r_mul});
            end
            S_NB: begin
                r_zr <= clamp32(sat_add(w_d, 64'(r_cr)));
                r_zi <= clamp32(sat_add(r_sx, 64'(r_ci)));
            end
            S_QA: begin
                r_t10 <= sat_scale(r_res[TAG_RI], 5'sd10);
                r_t5r <= sat_scale(r_res[TAG_R4], 5'sd5);
                r_t5i <= sat_scale(r_res[TAG_I4], 5'sd5);
            end
            S_QB: begin
                r_br <= sat_add(sat_sub(r_res[TAG_R4], r_t10), r_t5i);
                r_bi <= sat_add(sat_sub(r_t5r, r_t10), r_res[TAG_I4]);
            end
            S_QE: begin
                r_zr <= clamp32(sat_add(r_res[TAG_NR], 64'(r_cr)));
                r_zi <= clamp32(sat_add(r_res[TAG_NI], 64'(r_ci)));
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_WIDTH'(r_count);
endmodule

@@ rtl/etfi_checker.sv @@
// Port-level checks for the escape-time iterator, bound to the top level.
// Depends on etfi_pkg and escape_time_fractal_iterator_core.
module etfi_checker import etfi_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_WIDTH-1:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in work");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result waits");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> COUNT_WIDTH) == '0)
        else $error("padding bits set");
endmodule

bind escape_time_fractal_iterator_core etfi_checker u_etfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
